[sv/u8nc_pkg.sv]
// ----------------------------------------------------------------------------
// u8nc_pkg
// Shared types, constants and lookup functions of the UTF-8 to node-charset
// converter.
// ----------------------------------------------------------------------------
package u8nc_pkg;

  localparam int unsigned FifoDepthDefault = 4;
  localparam int unsigned AddrWidth        = 3;
  localparam int unsigned DataWidth        = 32;

  localparam logic [7:0] LEAD_BYTE      = 8'hC3;
  localparam logic [7:0] FILL_BYTE      = 8'h3F;
  localparam logic [7:0] TERM_BYTE      = 8'h00;
  localparam logic [7:0] MAX_LEN_RESET  = 8'hFF;
  localparam logic [7:0] COUNT_SAT      = 8'hFF;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // register index, taken from paddr above the byte offset
  localparam logic REG_MAX_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_END,
    CMD_FILL_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       status;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] node;
  } lookup_t;

  function automatic lookup_t pair_lookup(input logic [7:0] second);
    lookup_t r;
    r.hit = 1'b1;
    case (second)
      8'h85:   r.node = 8'd197;
      8'h86:   r.node = 8'd146;
      8'h98:   r.node = 8'd216;
      8'hA5:   r.node = 8'd229;
      8'hA6:   r.node = 8'd145;
      8'hB8:   r.node = 8'd248;
      8'h84:   r.node = 8'd196;
      8'hA4:   r.node = 8'd132;
      8'h96:   r.node = 8'd153;
      8'hB6:   r.node = 8'd148;
      default: begin
        r.hit  = 1'b0;
        r.node = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic logic plain_ok(input logic [7:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h2C:8'h39], 8'h3A, 8'h20};
  endfunction

endpackage

[sv/utf8_to_node_charset.sv]
// ----------------------------------------------------------------------------
// utf8_to_node_charset
// Converts a zero-terminated UTF-8 byte stream into node-charset bytes,
// with a length limit and a status on the terminator.
// ----------------------------------------------------------------------------
//  channel   ports                              transfer when
//  input     push, full, in_byte                push && !full
//  result    pop, empty, out_byte, is_last,     pop && !empty
//            status
//  config    psel, penable, pwrite, paddr,      psel && penable && pwrite
//            pwdata, prdata, pready
//
//  one input byte is taken per cycle while the command queue is not full; a
//  result is registered into the output register from the head of the queue.
//  a terminator that needs a fill byte occupies the output register for two
//  results, fill byte then terminator; the queue absorbs the difference.
//  full follows the command queue; empty follows the output register.
//  reset clears the string state, the queue and max_length to 255.
// ----------------------------------------------------------------------------
module utf8_to_node_charset import u8nc_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_byte,
  input  logic                 pop,
  output logic                 empty,
  output logic [7:0]           out_byte,
  output logic                 is_last,
  output logic                 status,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  logic [7:0] max_length;
  logic       accept;
  logic       cmd_valid;
  cmd_t       front_cmd;
  cmd_t       fifo_cmd;
  logic       fifo_empty;
  logic       fifo_pop;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[AddrWidth-1] == REG_MAX_LENGTH);
  assign prdata  = reg_sel ? {{(DataWidth-8){1'b0}}, max_length} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      max_length <= pwdata[7:0];
    end
  end

  assign accept = push && !full;

  u8nc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .max_length(max_length),
    .cmd_valid (cmd_valid),
    .cmd       (front_cmd)
  );

  u8nc_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_valid),
    .wr_data(front_cmd),
    .rd_en  (fifo_pop),
    .rd_data(fifo_cmd),
    .full   (full),
    .empty  (fifo_empty)
  );

  u8nc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (fifo_cmd),
    .cmd_empty(fifo_empty),
    .cmd_pop  (fifo_pop),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .is_last  (is_last),
    .status   (status)
  );

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> is_last)
    else $error("status set on a non-terminator result");

  a_last_is_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_last) |-> (out_byte == TERM_BYTE))
    else $error("terminator result carries a nonzero byte");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queue or output register not cleared by reset");

  // only checked in the first cycle the terminator is shown
  a_empty_term_fill: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_last && status && $past(empty || pop))
      |-> $past(!empty && out_byte == FILL_BYTE))
    else $error("empty-string terminator not preceded by fill byte");

endmodule

[sv/u8nc_front.sv]
// ----------------------------------------------------------------------------
// u8nc_front
// Takes input bytes, tracks the per-string state and turns each byte into
// at most one command for the back end.
// ----------------------------------------------------------------------------
module u8nc_front import u8nc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic [7:0] max_length,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  logic       lead_pending, lead_pending_next;
  logic       produced_any, produced_any_next;
  logic       seen_input, seen_input_next;
  logic [7:0] emitted_count, emitted_count_next;

  lookup_t    lk;
  logic       gen;
  logic [7:0] gen_byte;

  assign lk = pair_lookup(in_byte);

  always_comb begin
    lead_pending_next  = lead_pending;
    produced_any_next  = produced_any;
    seen_input_next    = seen_input;
    emitted_count_next = emitted_count;
    gen                = 1'b0;
    gen_byte           = FILL_BYTE;
    cmd_valid          = 1'b0;
    cmd.kind           = CMD_BYTE;
    cmd.data           = FILL_BYTE;
    cmd.status         = STATUS_OK;

    if (in_byte == TERM_BYTE) begin
      cmd_valid = 1'b1;
      cmd.data  = TERM_BYTE;
      if (!seen_input) begin
        cmd.kind   = CMD_FILL_END;
        cmd.status = STATUS_EMPTY;
      end else if (!produced_any && max_length != 8'd0) begin
        cmd.kind = CMD_FILL_END;
      end else begin
        cmd.kind = CMD_END;
      end
      lead_pending_next  = 1'b0;
      produced_any_next  = 1'b0;
      seen_input_next    = 1'b0;
      emitted_count_next = 8'd0;
    end else begin
      seen_input_next = 1'b1;
      if (lead_pending) begin
        lead_pending_next = 1'b0;
        gen               = lk.hit;
        gen_byte          = lk.node;
      end else if (in_byte == LEAD_BYTE) begin
        lead_pending_next = 1'b1;
      end else if (plain_ok(in_byte)) begin
        gen      = 1'b1;
        gen_byte = in_byte;
      end else begin
        gen = 1'b1;
      end

      if (gen) begin
        produced_any_next = 1'b1;
        if (emitted_count != COUNT_SAT) begin
          emitted_count_next = emitted_count + 8'd1;
        end
        if (emitted_count < max_length) begin
          cmd_valid = 1'b1;
          cmd.data  = gen_byte;
        end
      end
    end

    if (!accept) begin
      cmd_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending  <= 1'b0;
      produced_any  <= 1'b0;
      seen_input    <= 1'b0;
      emitted_count <= 8'd0;
    end else if (accept) begin
      lead_pending  <= lead_pending_next;
      produced_any  <= produced_any_next;
      seen_input    <= seen_input_next;
      emitted_count <= emitted_count_next;
    end
  end

endmodule

[sv/u8nc_fifo.sv]
// ----------------------------------------------------------------------------
// u8nc_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module u8nc_fifo import u8nc_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic full,
  output logic empty
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr  = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] FullCnt  = CntWidth'(Depth);

  cmd_t                mem [Depth];
  logic [PtrWidth-1:0] wr_ptr, rd_ptr;
  logic [CntWidth-1:0] count;
  logic                do_wr, do_rd;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/u8nc_back.sv]
// ----------------------------------------------------------------------------
// u8nc_back
// Expands queued commands into result bytes and holds them in an output
// register until the consumer takes them.
// ----------------------------------------------------------------------------
module u8nc_back import u8nc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic       cmd_empty,
  output logic       cmd_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       is_last,
  output logic       status
);

  logic       out_valid;
  logic       end_pending;
  logic       end_status;
  logic       load;
  logic [7:0] byte_next;
  logic       last_next;
  logic       status_next;

  assign empty   = !out_valid;
  assign load    = !out_valid || pop;
  assign cmd_pop = load && !end_pending && !cmd_empty;

  always_comb begin
    byte_next   = TERM_BYTE;
    last_next   = 1'b1;
    status_next = end_status;
    if (!end_pending) begin
      case (cmd.kind)
        CMD_BYTE: begin
          byte_next   = cmd.data;
          last_next   = 1'b0;
          status_next = STATUS_OK;
        end
        CMD_END: begin
          status_next = cmd.status;
        end
        CMD_FILL_END: begin
          byte_next   = FILL_BYTE;
          last_next   = 1'b0;
          status_next = STATUS_OK;
        end
        default: begin
          status_next = cmd.status;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      end_pending <= 1'b0;
    end else if (load) begin
      if (end_pending) begin
        out_valid   <= 1'b1;
        end_pending <= 1'b0;
      end else if (!cmd_empty) begin
        out_valid   <= 1'b1;
        end_pending <= (cmd.kind == CMD_FILL_END);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && (end_pending || !cmd_empty)) begin
      out_byte <= byte_next;
      is_last  <= last_next;
      status   <= status_next;
    end
    if (cmd_pop) begin
      end_status <= cmd.status;
    end
  end

endmodule

[test/utf8_to_node_charset_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_node_charset_tb
// Streams zero-terminated UTF-8 strings into the converter under random push
// and pop gaps, predicts every node-charset byte and terminator in the bench,
// and compares each popped transfer field by field. max_length is rewritten
// between phases while the block is idle, reset value and extremes included.
// ----------------------------------------------------------------------------
module utf8_to_node_charset_tb;
  import u8nc_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_last;
    logic       status;
  } node_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           in_byte = 8'h00;
  logic                 pop = 1'b0;
  logic                 empty;
  logic [7:0]           out_byte;
  logic                 is_last;
  logic                 status;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  logic [7:0]   pending_bytes[$];
  node_result_t node_bytes_due[$];
  node_result_t head_result;

  // bench copy of the converter state
  logic [7:0] max_len_q = MAX_LEN_RESET;
  logic       lead_seen = 1'b0;
  logic       any_generated = 1'b0;
  logic       any_input = 1'b0;
  logic [7:0] gen_count = 8'h00;

  logic        idle_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  logic [7:0] nordic_seconds [10] = '{8'h85, 8'h86, 8'h98, 8'hA5, 8'hA6,
                                      8'hB8, 8'h84, 8'hA4, 8'h96, 8'hB6};

  // reset-value strings, then max_length 0, then max_length 1
  logic [7:0] directed_bytes [35] = '{
    8'h00, "A", "z", ",", "9", ":", " ", 8'h7F, 8'hFF, 8'h2B, 8'h5B,
    LEAD_BYTE, 8'h85, LEAD_BYTE, 8'hB6, LEAD_BYTE, 8'h41, LEAD_BYTE, LEAD_BYTE,
    LEAD_BYTE, 8'h00, LEAD_BYTE, 8'h41, 8'h00,
    LEAD_BYTE, 8'h00, 8'h00, "A", 8'h00,
    "A", "B", 8'h00, LEAD_BYTE, 8'h41, 8'h00
  };

  utf8_to_node_charset u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_byte (in_byte),
    .pop     (pop),
    .empty   (empty),
    .out_byte(out_byte),
    .is_last (is_last),
    .status  (status),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic emit_node_byte(input logic [7:0] b);
    if (gen_count < max_len_q) node_bytes_due.push_back('{b, 1'b0, STATUS_OK});
    if (gen_count != COUNT_SAT) gen_count++;
    any_generated = 1'b1;
  endtask

  task automatic predict_node_bytes(input logic [7:0] b);
    logic [7:0] letter;
    logic       hit;
    if (b == TERM_BYTE) begin
      if (!any_input) begin
        node_bytes_due.push_back('{FILL_BYTE, 1'b0, STATUS_OK});
        node_bytes_due.push_back('{TERM_BYTE, 1'b1, STATUS_EMPTY});
      end else begin
        if (!any_generated && max_len_q != 8'd0)
          node_bytes_due.push_back('{FILL_BYTE, 1'b0, STATUS_OK});
        node_bytes_due.push_back('{TERM_BYTE, 1'b1, STATUS_OK});
      end
      lead_seen     = 1'b0;
      any_generated = 1'b0;
      any_input     = 1'b0;
      gen_count     = 8'h00;
    end else begin
      any_input = 1'b1;
      if (lead_seen) begin
        lead_seen = 1'b0;
        hit       = 1'b1;
        letter    = 8'h00;
        case (b)
          8'h85:   letter = 8'd197;
          8'h86:   letter = 8'd146;
          8'h98:   letter = 8'd216;
          8'hA5:   letter = 8'd229;
          8'hA6:   letter = 8'd145;
          8'hB8:   letter = 8'd248;
          8'h84:   letter = 8'd196;
          8'hA4:   letter = 8'd132;
          8'h96:   letter = 8'd153;
          8'hB6:   letter = 8'd148;
          default: hit = 1'b0;
        endcase
        if (hit) emit_node_byte(letter);
      end else if (b == LEAD_BYTE) begin
        lead_seen = 1'b1;
      end else if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
                   (b >= "," && b <= "9") || b == ":" || b == " ") begin
        emit_node_byte(b);
      end else begin
        emit_node_byte(FILL_BYTE);
      end
    end
  endtask

  function automatic logic [7:0] pick_plain();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(8'h41, 8'h5A));
      1:       return 8'($urandom_range(8'h61, 8'h7A));
      2:       return 8'($urandom_range(8'h2C, 8'h39));
      3:       return ":";
      default: return " ";
    endcase
  endfunction

  task automatic queue_directed(input int first, input int count);
    for (int i = first; i < first + count; i++) pending_bytes.push_back(directed_bytes[i]);
  endtask

  // mostly well-formed text with letters and lead-byte pairs, some noise
  task automatic queue_strings(input int n_items);
    int added;
    int len;
    added = 0;
    while (added < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: begin
            pending_bytes.push_back(pick_plain());
            added++;
          end
          8, 9, 10, 11, 12: begin
            pending_bytes.push_back(LEAD_BYTE);
            pending_bytes.push_back(nordic_seconds[$urandom_range(0, 9)]);
            added += 2;
          end
          13: begin
            pending_bytes.push_back(LEAD_BYTE);
            pending_bytes.push_back(8'($urandom_range(1, 255)));
            added += 2;
          end
          14: begin
            pending_bytes.push_back(LEAD_BYTE);
            added++;
          end
          default: begin
            pending_bytes.push_back(8'($urandom_range(1, 255)));
            added++;
          end
        endcase
      end
      pending_bytes.push_back(TERM_BYTE);
      added++;
    end
  endtask

  task automatic queue_plain_run(input int len);
    for (int i = 0; i < len; i++) pending_bytes.push_back(pick_plain());
    pending_bytes.push_back(TERM_BYTE);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || push || node_bytes_due.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic apb_write(input logic [DataWidth-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrWidth'({REG_MAX_LENGTH, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    max_len_q  = value[7:0];
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) predict_node_bytes(in_byte);
      if (!push || !full) begin
        if (send_gap == 0 && idle_on && $urandom_range(0, 9) == 0)
          send_gap = $urandom_range(1, 8);
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          push    <= 1'b1;
          in_byte <= pending_bytes.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (node_bytes_due.size() == 0) begin
          $display("%0t: unexpected transfer, out_byte %0h is_last %0b status %0b",
                   $time, out_byte, is_last, status);
          mismatch_count++;
        end else begin
          head_result = node_bytes_due.pop_front();
          if (out_byte !== head_result.out_byte) begin
            $display("%0t: out_byte expected %0h actual %0h",
                     $time, head_result.out_byte, out_byte);
            mismatch_count++;
          end
          if (is_last !== head_result.is_last) begin
            $display("%0t: is_last expected %0b actual %0b",
                     $time, head_result.is_last, is_last);
            mismatch_count++;
          end
          if (status !== head_result.status) begin
            $display("%0t: status expected %0b actual %0b",
                     $time, head_result.status, status);
            mismatch_count++;
          end
        end
      end
      if (take_gap == 0 && idle_on && $urandom_range(0, 9) == 0)
        take_gap = $urandom_range(1, 8);
      if (take_gap > 0) begin
        take_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // max_length at its reset value
    queue_directed(0, 24);
    queue_strings(150);
    wait_drained();

    apb_write(32'd0);
    queue_directed(24, 5);
    queue_strings(150);
    wait_drained();

    apb_write(32'd1);
    queue_directed(29, 6);
    queue_strings(150);
    wait_drained();

    // string left open with a lead byte across the next register write
    apb_write(32'd3);
    queue_strings(150);
    queue_plain_run(40);
    pending_bytes.push_back("x");
    pending_bytes.push_back("y");
    pending_bytes.push_back(LEAD_BYTE);
    wait_drained();

    apb_write($urandom);
    queue_strings(150);
    wait_drained();

    // count saturation with no idling on either side
    apb_write({24'($urandom), 8'hFF});
    idle_on = 1'b0;
    queue_strings(100);
    queue_plain_run(300);
    wait_drained();

    if (mismatch_count == 0 && node_bytes_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
